// File: rtl/emc_pkg.sv
// ----------------------------------------------------------------------------
// emc_pkg
// Shared types, register codes and constants for the element-wise combiner.
// ----------------------------------------------------------------------------
package emc_pkg;

    localparam int NUM_INPUTS_DEF = 4;
    localparam int MAX_INPUTS     = 4;

    // operation codes
    localparam logic [2:0] OP_SUM  = 3'd0;
    localparam logic [2:0] OP_ABS  = 3'd1;
    localparam logic [2:0] OP_EUCL = 3'd2;
    localparam logic [2:0] OP_PROD = 3'd3;
    localparam logic [2:0] OP_MAX  = 3'd4;

    // register indexes
    localparam logic [2:0] REG_OP_MODE       = 3'd0;
    localparam logic [2:0] REG_COEFF_MODE    = 3'd1;
    localparam logic [2:0] REG_ACTIVE_INPUTS = 3'd2;
    localparam logic [2:0] REG_WEIGHTS       = 3'd3;
    localparam logic [2:0] REG_SHIFTS        = 3'd4;

    localparam logic [63:0] WEIGHTS_RST = 64'h1000_1000_1000_1000;

    // square root: 40-bit radicand, 20-bit root, one bit per stage
    localparam int RAD_W  = 40;
    localparam int ROOT_W = 20;
    localparam int REM_W  = 22;

    localparam int LIN_W = 34;
    localparam int EU_W  = 62;

    typedef struct packed {
        logic signed [15:0] value_0;
        logic signed [15:0] value_1;
        logic signed [15:0] value_2;
        logic signed [15:0] value_3;
        logic signed [15:0] channel_weight;
        logic signed [15:0] channel_shift;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         max_index;
        logic               saturated;
    } res_item_t;

    typedef struct packed {
        logic [2:0]  op_mode;
        logic        coeff_mode;
        logic [2:0]  active_inputs;
        logic [63:0] input_weights;
        logic [63:0] input_shifts;
    } cfg_t;

    typedef struct packed {
        logic signed [LIN_W-1:0] lin;
        logic [EU_W-1:0]         eu;
    } lane_out_t;

    typedef struct packed {
        res_item_t byp;
        logic      is_eu;
    } tag_t;

    function automatic logic signed [15:0] item_value(in_item_t it, int k);
        logic signed [15:0] v;
        unique case (k)
            0:       v = it.value_0;
            1:       v = it.value_1;
            2:       v = it.value_2;
            default: v = it.value_3;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/elementwise_multi_input_combiner_core.sv
// ----------------------------------------------------------------------------
// elementwise_multi_input_combiner_core
// Combines one element position of up to four tensors into one Q24.8 value.
// ----------------------------------------------------------------------------
// A new item is taken on every clock cycle (busy never rises) and its result
// is on result with done high for one cycle after it has passed through
// three register stages of lane multipliers and merging and then twenty
// stages of the square-root pipeline, which resolves one root bit per
// stage; every mode goes through the same depth so results leave in
// order. The receiver cannot stall the block: each result is shown for
// one cycle only. Configuration writes are always ready and must only be
// issued while no item is in flight.
module elementwise_multi_input_combiner_core #(
    parameter int NUM_INPUTS = emc_pkg::NUM_INPUTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  emc_pkg::in_item_t  item,
    output logic               done,
    output emc_pkg::res_item_t result,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_data
);
    import emc_pkg::*;

    cfg_t       cfg_reg;
    logic [2:0] n_eff;
    logic [2:0] vld_reg;
    lane_out_t  lanes [NUM_INPUTS];
    tag_t       mtag, stag;
    logic [RAD_W-1:0]  rad;
    logic [ROOT_W-1:0] root;
    logic              sq_valid;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.op_mode       <= OP_SUM;
            cfg_reg.coeff_mode    <= 1'b0;
            cfg_reg.active_inputs <= 3'd2;
            cfg_reg.input_weights <= WEIGHTS_RST;
            cfg_reg.input_shifts  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OP_MODE:       cfg_reg.op_mode       <= cfg_data[2:0];
                REG_COEFF_MODE:    cfg_reg.coeff_mode    <= cfg_data[0];
                REG_ACTIVE_INPUTS: cfg_reg.active_inputs <= cfg_data[2:0];
                REG_WEIGHTS:       cfg_reg.input_weights <= cfg_data;
                REG_SHIFTS:        cfg_reg.input_shifts  <= cfg_data;
                default:           cfg_reg.op_mode       <= cfg_reg.op_mode;
            endcase
        end
    end

    // clamp the input count to one .. NUM_INPUTS
    always_comb
    begin
        if (cfg_reg.active_inputs == 3'd0)
            n_eff = 3'd1;
        else if (cfg_reg.active_inputs > 3'(NUM_INPUTS))
            n_eff = 3'(NUM_INPUTS);
        else
            n_eff = cfg_reg.active_inputs;
    end

    // advance item valid through the merge stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[1:0], start && !busy};
    end

    for (genvar k = 0; k < NUM_INPUTS; k++)
    begin : g_lane
        emc_lane #(.LANE(k)) u_lane (
            .clk      (clk),
            .cfg      (cfg_reg),
            .item     (item),
            .active   (3'(k) < n_eff),
            .lane_out (lanes[k])
        );
    end

    emc_merge #(.NUM_INPUTS(NUM_INPUTS)) u_merge (
        .clk   (clk),
        .cfg   (cfg_reg),
        .item  (item),
        .n_eff (n_eff),
        .lanes (lanes),
        .tag   (mtag),
        .rad   (rad)
    );

    emc_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (vld_reg[2]),
        .rad       (rad),
        .tag_in    (mtag),
        .out_valid (sq_valid),
        .root      (root),
        .tag_out   (stag)
    );

    // drop in the root for the Euclidean mode
    always_comb
    begin
        result = stag.byp;
        if (stag.is_eu)
        begin
            result.result_value = 32'({1'b0, root});
            result.max_index    = '0;
            result.saturated    = 1'b0;
        end
    end

    assign done = sq_valid;

endmodule

// File: rtl/emc_lane.sv
// ----------------------------------------------------------------------------
// emc_lane
// One input lane: weighted linear term and squared Euclidean term, two stages.
// ----------------------------------------------------------------------------
module emc_lane #(
    parameter int LANE = 0
) (
    input  logic              clk,
    input  emc_pkg::cfg_t     cfg,
    input  emc_pkg::in_item_t item,
    input  logic              active,
    output emc_pkg::lane_out_t lane_out
);
    import emc_pkg::*;

    logic signed [15:0] x, wk, sk, w_sel, s_sel;
    logic [16:0]        ax;
    logic signed [31:0] wx;
    logic signed [32:0] wa;
    logic signed [LIN_W-1:0] lin_next;
    logic [30:0] w2_next, x2_next, s2_next;

    logic signed [LIN_W-1:0] lin1_reg, lin2_reg;
    logic [30:0] w2_reg, x2_reg, s2_reg;
    logic [EU_W-1:0] eu_reg;

    // pick coefficients and form the linear term
    always_comb
    begin
        x     = item_value(item, LANE);
        wk    = $signed(cfg.input_weights[16*LANE +: 16]);
        sk    = $signed(cfg.input_shifts[16*LANE +: 16]);
        w_sel = (cfg.coeff_mode && cfg.op_mode == OP_SUM) ? item.channel_weight : wk;
        s_sel = (cfg.coeff_mode && cfg.op_mode == OP_SUM) ? item.channel_shift : sk;
        ax    = x[15] ? 17'(-{x[15], x}) : {1'b0, x};
        wx    = w_sel * x;
        wa    = wk * $signed({1'b0, ax});
        if (cfg.op_mode == OP_ABS)
            lin_next = LIN_W'(wa);
        else
            lin_next = LIN_W'(wx) + LIN_W'($signed({s_sel, 12'b0}));
        w2_next = 31'(wk * wk);
        x2_next = 31'(x * x);
        s2_next = 31'(sk * sk);
        if (!active)
        begin
            lin_next = '0;
            w2_next  = '0;
            x2_next  = '0;
            s2_next  = '0;
        end
    end

    // stage 1 products, stage 2 squared term
    always_ff @(posedge clk)
    begin
        lin1_reg <= lin_next;
        w2_reg   <= w2_next;
        x2_reg   <= x2_next;
        s2_reg   <= s2_next;
        lin2_reg <= lin1_reg;
        eu_reg   <= EU_W'(w2_reg * x2_reg) + EU_W'({s2_reg, 24'b0});
    end

    assign lane_out.lin = lin2_reg;
    assign lane_out.eu  = eu_reg;

endmodule

// File: rtl/emc_merge.sv
// ----------------------------------------------------------------------------
// emc_merge
// Merge lane results: sums, product, maximum; stage-3 result and radicand.
// ----------------------------------------------------------------------------
module emc_merge #(
    parameter int NUM_INPUTS = emc_pkg::NUM_INPUTS_DEF
) (
    input  logic               clk,
    input  emc_pkg::cfg_t      cfg,
    input  emc_pkg::in_item_t  item,
    input  logic [2:0]         n_eff,
    input  emc_pkg::lane_out_t lanes [NUM_INPUTS],
    output emc_pkg::tag_t      tag,
    output logic [emc_pkg::RAD_W-1:0] rad
);
    import emc_pkg::*;

    logic signed [15:0] x1e, x2e, x3e, best;
    logic [1:0]         best_idx;
    logic signed [31:0] p01_reg, p23_reg;
    logic signed [15:0] max1_reg, max2_reg;
    logic [1:0]         idx1_reg, idx2_reg;
    logic signed [63:0] p_reg;
    logic signed [63:0] pr;
    logic signed [35:0] acc;
    logic signed [35:0] acc_r;
    logic [63:0]        vsum;
    res_item_t          byp_next;
    tag_t               tag_reg;
    logic [RAD_W-1:0]   rad_reg;

    // inactive factors count as one, find maximum with lowest index on ties
    always_comb
    begin
        x1e = (n_eff >= 3'd2) ? item.value_1 : 16'sd1;
        x2e = (n_eff >= 3'd3) ? item.value_2 : 16'sd1;
        x3e = (n_eff >= 3'd4) ? item.value_3 : 16'sd1;
        best     = item.value_0;
        best_idx = '0;
        for (int k = 1; k < NUM_INPUTS; k++)
        begin
            if (3'(k) < n_eff && item_value(item, k) > best)
            begin
                best     = item_value(item, k);
                best_idx = 2'(k);
            end
        end
    end

    // stages 1 and 2: product tree and carried maximum
    always_ff @(posedge clk)
    begin
        p01_reg  <= item.value_0 * x1e;
        p23_reg  <= x2e * x3e;
        max1_reg <= best;
        idx1_reg <= best_idx;
        p_reg    <= p01_reg * p23_reg;
        max2_reg <= max1_reg;
        idx2_reg <= idx1_reg;
    end

    // reduce lanes, round, clip and select the non-root result
    always_comb
    begin
        acc  = '0;
        vsum = '0;
        for (int k = 0; k < NUM_INPUTS; k++)
        begin
            acc  = acc + 36'(lanes[k].lin);
            vsum = vsum + 64'(lanes[k].eu);
        end
        acc_r = (acc + 36'sd2048) >>> 12;
        unique case (n_eff)
            3'd2:    pr = (p_reg + 64'sd128) >>> 8;
            3'd3:    pr = (p_reg + 64'sd32768) >>> 16;
            3'd4:    pr = (p_reg + 64'sd8388608) >>> 24;
            default: pr = p_reg;
        endcase
        byp_next = '0;
        unique case (cfg.op_mode)
            OP_SUM, OP_ABS:
            begin
                byp_next.result_value = 32'(acc_r);
            end
            OP_PROD:
            begin
                if (pr > 64'sd2147483647)
                begin
                    byp_next.result_value = 32'sh7FFF_FFFF;
                    byp_next.saturated    = 1'b1;
                end
                else if (pr < -64'sd2147483648)
                begin
                    byp_next.result_value = 32'sh8000_0000;
                    byp_next.saturated    = 1'b1;
                end
                else
                begin
                    byp_next.result_value = 32'(pr);
                end
            end
            OP_MAX:
            begin
                byp_next.result_value = 32'(max2_reg);
                byp_next.max_index    = idx2_reg;
            end
            default: byp_next = '0;
        endcase
    end

    // stage 3: hold the merged item
    always_ff @(posedge clk)
    begin
        tag_reg.byp   <= byp_next;
        tag_reg.is_eu <= (cfg.op_mode == OP_EUCL);
        rad_reg       <= vsum[63:24];
    end

    assign tag = tag_reg;
    assign rad = rad_reg;

endmodule

// File: rtl/emc_isqrt.sv
// ----------------------------------------------------------------------------
// emc_isqrt
// Pipelined integer square root, one root bit per stage, carries a tag.
// ----------------------------------------------------------------------------
module emc_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic [emc_pkg::RAD_W-1:0]  rad,
    input  emc_pkg::tag_t              tag_in,
    output logic                       out_valid,
    output logic [emc_pkg::ROOT_W-1:0] root,
    output emc_pkg::tag_t              tag_out
);
    import emc_pkg::*;

    logic [ROOT_W:0]    vld_reg;
    logic [RAD_W-1:0]   rad_reg  [ROOT_W+1];
    logic [REM_W-1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W-1:0]  root_reg [ROOT_W+1];
    tag_t               tag_reg  [ROOT_W+1];

    assign vld_reg[0]  = in_valid;
    assign rad_reg[0]  = rad;
    assign rem_reg[0]  = '0;
    assign root_reg[0] = '0;
    assign tag_reg[0]  = tag_in;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_stage
        logic [REM_W+1:0] rem_sh;
        logic [REM_W+1:0] trial;
        logic             fits;

        // shift in two radicand bits and try the next root bit
        always_comb
        begin
            rem_sh = {rem_reg[i], rad_reg[i][RAD_W-1 -: 2]};
            trial  = (REM_W+2)'({root_reg[i], 2'b01});
            fits   = (rem_sh >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[i+1] <= 1'b0;
            else
                vld_reg[i+1] <= vld_reg[i];
        end

        always_ff @(posedge clk)
        begin
            rad_reg[i+1]  <= {rad_reg[i][RAD_W-3:0], 2'b00};
            rem_reg[i+1]  <= fits ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
            root_reg[i+1] <= {root_reg[i][ROOT_W-2:0], fits};
            tag_reg[i+1]  <= tag_reg[i];
        end
    end

    assign out_valid = vld_reg[ROOT_W];
    assign root      = root_reg[ROOT_W];
    assign tag_out   = tag_reg[ROOT_W];

endmodule
